// ===== design/byte_rle_pkg.sv =====
package byte_rle_pkg;

  // chunk geometry and run limit
  localparam int unsigned CHUNK_ITEMS = 32768;
  localparam int          CODE_W      = 32;
  localparam int          BYTE_W      = 8;
  localparam int          COUNT_W     = 16;
  localparam logic [BYTE_W-1:0]  RUN_CAP   = 8'd255;
  localparam logic [COUNT_W:0]   CHUNK_END = (COUNT_W+1)'(CHUNK_ITEMS);

  // result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // one encoded pair with its flags
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] length;
    logic              last;
    logic              error;
  } rle_pair_t;

  // up to two pairs written by one input item, first in lane a
  typedef struct packed {
    logic      a_valid;
    logic      b_valid;
    rle_pair_t a;
    rle_pair_t b;
  } rle_push_t;

endpackage

// ===== design/byte_rle_queue.sv =====
module byte_rle_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  byte_rle_pkg::rle_push_t push,
  output logic                   room,
  output logic                   head_valid,
  output byte_rle_pkg::rle_pair_t head,
  input  logic                   head_take
);
  import byte_rle_pkg::*;

  rle_pair_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   pop;

  // room for the two pairs that one item can bring
  assign room       = (count_r <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid & head_take;

  // pointer and fill arithmetic
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QUEUE_PTR_W'(push.a_valid) + QUEUE_PTR_W'(push.b_valid);
    rd_ptr_nxt = rd_ptr_r + QUEUE_PTR_W'(pop);
    count_nxt  = count_r + QUEUE_CNT_W'(push.a_valid) + QUEUE_CNT_W'(push.b_valid)
                 - QUEUE_CNT_W'(pop);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, lane b lands behind lane a
  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      mem_r[wr_ptr_r] <= push.a;
    end
    if (push.b_valid) begin
      mem_r[wr_ptr_r + QUEUE_PTR_W'(1)] <= push.b;
    end
  end

endmodule

// ===== design/byte_run_length_encoder_core.sv =====
// Byte run-length encoder for chunks of item codes.
// Input channel in_*: one 32-bit signed item code per transaction. Codes are
// grouped into chunks of CHUNK_ITEMS items, counted from reset.
// Output channel out_*: one (value, length) pair per transaction. out_tlast
// marks the final pair of a chunk, out_tuser carries the sticky out-of-range
// flag of the chunk so far, which a consumer checks on the final pair.
// Runs of equal low bytes are counted up to 255; a differing code or a full
// run closes the pair. The final item of a chunk can close a run and flush
// its own, so it yields two pairs.
// A pair closed by an item is written to the result queue as the item is
// accepted. Throughput: one item per cycle while the queue has room; the
// run compare and chunk count sit in one stage ahead of a four-entry result
// queue, which drains one pair per cycle while out_tready is high.
// Reset (synchronous, rst_n low) clears the open run, item count, error flag
// and result queue; no clearing pass is needed.
// When the receiver stalls, pairs collect in the queue; in_tready drops once
// fewer than two entries are free and returns as the queue drains.
module byte_run_length_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] run_value, [15:8] run_length
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // [0] error
);
  import byte_rle_pkg::*;

  logic [BYTE_W-1:0]  val_r, val_nxt;
  logic [BYTE_W-1:0]  len_r, len_nxt;
  logic [COUNT_W-1:0] seen_r, seen_nxt;
  logic               error_r, error_nxt;

  logic               accept;
  logic [BYTE_W-1:0]  code_byte;
  logic               code_bad;
  logic               err_now;
  logic               extend;
  logic               close_run;
  logic [BYTE_W-1:0]  run_val_upd;
  logic [BYTE_W-1:0]  run_len_upd;
  logic [COUNT_W:0]   seen_inc;
  logic               chunk_end;
  rle_pair_t          closed_pair;
  rle_pair_t          final_pair;
  rle_push_t          push;
  logic               room;
  rle_pair_t          head;

  assign accept    = in_tvalid & in_tready;
  assign in_tready = room;

  // decode the incoming code
  assign code_byte = in_tdata[BYTE_W-1:0];
  assign code_bad  = |in_tdata[CODE_W-1:BYTE_W];
  assign err_now   = error_r | code_bad;

  // run extension or restart
  assign extend      = (len_r != '0) && (code_byte == val_r) && (len_r != RUN_CAP);
  assign close_run   = (len_r != '0) && !extend;
  assign run_val_upd = extend ? val_r : code_byte;
  assign run_len_upd = extend ? (len_r + BYTE_W'(1)) : BYTE_W'(1);

  // chunk position
  assign seen_inc  = {1'b0, seen_r} + (COUNT_W+1)'(1);
  assign chunk_end = (seen_inc >= CHUNK_END);

  // pairs produced by this item
  always_comb begin
    closed_pair = '{value: val_r, length: len_r, last: 1'b0, error: err_now};
    final_pair  = '{value: run_val_upd, length: run_len_upd, last: 1'b1, error: err_now};
    push.a_valid = accept & (close_run | chunk_end);
    push.b_valid = accept & close_run & chunk_end;
    push.a       = close_run ? closed_pair : final_pair;
    push.b       = final_pair;
  end

  // next run state
  always_comb begin
    val_nxt   = val_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    error_nxt = error_r;
    if (accept) begin
      val_nxt   = run_val_upd;
      len_nxt   = chunk_end ? '0 : run_len_upd;
      seen_nxt  = chunk_end ? '0 : seen_inc[COUNT_W-1:0];
      error_nxt = chunk_end ? 1'b0 : err_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r   <= '0;
      len_r   <= '0;
      seen_r  <= '0;
      error_r <= 1'b0;
    end else begin
      val_r   <= val_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      error_r <= error_nxt;
    end
  end

  // result queue decouples the stalled receiver
  byte_rle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_tvalid),
    .head       (head),
    .head_take  (out_tready)
  );

  assign out_tdata = {head.length, head.value};
  assign out_tlast = head.last;
  assign out_tuser = head.error;

endmodule

// ===== design/byte_rle_checker.sv =====
module byte_rle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  // nothing offered in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // every run holds at least one item
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:8] != 8'd0))
    else $error("run of zero length");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // input held off only while results are waiting
  a_full_offers: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input blocked with no result offered");

endmodule

bind byte_run_length_encoder_core byte_rle_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== tb/byte_run_length_encoder_core_tb.sv =====
module byte_run_length_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import byte_rle_pkg::*;

  localparam int unsigned STALL_PCT  = 11;
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT = 16;
  localparam int unsigned RAND_ITEMS = 860;

  // pair predictor and store of pending pairs
  class rle_scoreboard;
    logic [BYTE_W-1:0]  run_byte;
    logic [BYTE_W-1:0]  run_len;
    logic [COUNT_W-1:0] chunk_count;
    logic               chunk_err;
    rle_pair_t          pending_pairs[$];
    int unsigned        fails;

    function new();
      run_byte    = '0;
      run_len     = '0;
      chunk_count = '0;
      chunk_err   = 1'b0;
      fails       = 0;
    endfunction

    function void push_pair(logic [BYTE_W-1:0] v, logic [BYTE_W-1:0] l, logic fin);
      rle_pair_t p;
      p.value  = v;
      p.length = l;
      p.last   = fin;
      p.error  = chunk_err;
      pending_pairs = {pending_pairs, p};
    endfunction

    // advance the run state by one accepted code
    function void note_item(logic [CODE_W-1:0] code);
      logic [BYTE_W-1:0] b;
      b = code[BYTE_W-1:0];
      // negative codes have the top bit set, so an unsigned compare catches them
      if (code > 32'd255) chunk_err = 1'b1;
      if (run_len != '0 && b == run_byte && run_len < RUN_CAP) begin
        run_len = run_len + 1'b1;
      end else begin
        if (run_len != '0) push_pair(run_byte, run_len, 1'b0);
        run_byte = b;
        run_len  = 8'd1;
      end
      chunk_count = chunk_count + 1'b1;
      // end of chunk: flush the open run as the final pair
      if (32'(chunk_count) >= CHUNK_ITEMS) begin
        push_pair(run_byte, run_len, 1'b1);
        run_len     = '0;
        chunk_count = '0;
        chunk_err   = 1'b0;
      end
    endfunction

    function void check_pair(logic [BYTE_W-1:0] v, logic [BYTE_W-1:0] l,
                             logic fin, logic err);
      rle_pair_t p;
      if (pending_pairs.size() == 0) begin
        $error("unexpected pair: run_value %0d run_length %0d last %0b error %0b",
               v, l, fin, err);
        fails++;
      end else begin
        p = pending_pairs.pop_front();
        if (v !== p.value) begin
          $error("run_value: expected %0d, got %0d", p.value, v);
          fails++;
        end
        if (l !== p.length) begin
          $error("run_length: expected %0d, got %0d", p.length, l);
          fails++;
        end
        if (fin !== p.last) begin
          $error("last: expected %0b, got %0b", p.last, fin);
          fails++;
        end
        if (err !== p.error) begin
          $error("error: expected %0b, got %0b", p.error, err);
          fails++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_pairs.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  rle_scoreboard     sb = new();
  bit                calm = 1'b0;
  logic [BYTE_W-1:0] last_byte = '0;
  int unsigned       hang_count = 0;

  byte_run_length_encoder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_pair(out_tdata[7:0], out_tdata[15:8], out_tlast, out_tuser[0]);
      if (in_tvalid && in_tready) sb.note_item(in_tdata);
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  // one code, held until accepted
  task automatic send_item(input logic [31:0] code);
    if (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    last_byte = code[7:0];
  endtask

  // a run of one byte, some codes pushed out of range with the same low byte
  task automatic send_run(input logic [7:0] b, input int unsigned len,
                          input int unsigned err_pct);
    logic [31:0] code;
    for (int unsigned i = 0; i < len; i++) begin
      code = {24'h0, b};
      if ($urandom_range(0, 99) < err_pct) begin
        code[31:8] = 24'($urandom);
        if (code[31:8] == 24'h0) code[8] = 1'b1;
      end
      send_item(code);
    end
  endtask

  initial begin
    logic [31:0]  edge_codes[] = '{
      32'h0000_0000, 32'h0000_0000, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF,
      32'h0000_0100, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h0000_00AA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h0000_0002,
      32'h0000_0002, 32'h0000_0080
    };
    int unsigned  rand_sent;
    int unsigned  pick;
    int unsigned  len;
    logic [7:0]   b;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, out-of-range codes, runs across the cap
    foreach (edge_codes[i]) send_item(edge_codes[i]);
    send_run(8'h5A, 300, 0);
    send_run(8'h3C, 255, 0);
    send_run(8'h3D, 1, 0);

    // random runs with noise, a calm stretch in the middle
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      calm = (rand_sent >= 300 && rand_sent < 600);
      pick = $urandom_range(0, 99);
      if (pick < 60)      b = 8'($urandom_range(0, 255));
      else if (pick < 75) b = last_byte;
      else if (pick < 85) b = 8'h00;
      else                b = 8'hFF;
      pick = $urandom_range(0, 99);
      if (pick < 80)      len = $urandom_range(1, 6);
      else if (pick < 96) len = $urandom_range(7, 60);
      else                len = $urandom_range(240, 300);
      if ($urandom_range(0, 9) == 0) begin
        for (int unsigned i = 0; i < len; i++) send_item($urandom);
      end else begin
        send_run(b, len, 4);
      end
      rand_sent += len;
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/byte_rle_pkg.sv
design/byte_rle_queue.sv
design/byte_run_length_encoder_core.sv
design/byte_rle_checker.sv
tb/byte_run_length_encoder_core_tb.sv
